// ===== rtl/signed_integer_divider_assert.svh =====
// Assertion helpers for the signed integer divider.
// Each check runs on the rising edge of i_clk and is held off while i_rst_n is low.
`ifndef SIGNED_INTEGER_DIVIDER_ASSERT_SVH
`define SIGNED_INTEGER_DIVIDER_ASSERT_SVH

// Same-cycle implication.
`define SID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("signed_integer_divider: check failed");

// Next-cycle implication.
`define SID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("signed_integer_divider: check failed");

`endif

// ===== rtl/sid_pkg.sv =====
package sid_pkg;

    localparam int OPERAND_W      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [OPERAND_W-1:0] dividend;
        logic signed [OPERAND_W-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        logic signed [OPERAND_W-1:0] quotient;
        t_status                     status;
    } t_div_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;    // capture operand magnitudes and signs
        logic step;    // one restoring iteration
        logic finish;  // sign fix, saturation, result register
    } t_dp_cmd;

endpackage

// ===== rtl/sid_ctrl.sv =====
module sid_ctrl #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output sid_pkg::t_dp_cmd o_cmd
);

    localparam int CW = $clog2(DATA_WIDTH);

    sid_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sid_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_busy  = (r_state != sid_pkg::S_IDLE);
        unique case (r_state)
            sid_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CW'(DATA_WIDTH - 1);
                    n_state    = sid_pkg::S_DIV;
                end
            end
            sid_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = sid_pkg::S_FIN;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            sid_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = sid_pkg::S_IDLE;
            end
            default: begin
                n_state = sid_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sid_datapath.sv =====
module sid_datapath #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sid_pkg::t_dp_cmd  i_cmd,
    input  sid_pkg::t_div_in  i_operands,
    output logic              o_done,
    output sid_pkg::t_div_out o_result
);

    localparam int DW = DATA_WIDTH;
    localparam int OW = sid_pkg::OPERAND_W;

    // operands cut or zero-extended to DW bits
    logic [DW+OW-1:0] w_ext_a, w_ext_b;
    logic [DW-1:0]    w_a, w_b, w_mag_a, w_mag_b;
    logic             w_neg_a, w_neg_b;

    logic [DW-1:0]    r_den, r_rem, r_quo;
    logic             r_neg;

    logic [DW-1:0]    w_shift;
    logic [DW:0]      w_diff;
    logic             w_fits;

    logic [DW-1:0]    w_maxpos, w_q;
    sid_pkg::t_status w_status;
    logic [DW+OW-1:0] w_q_ext;

    sid_pkg::t_div_out r_result;
    logic              r_done;

    assign w_ext_a = {{DW{1'b0}}, i_operands.dividend};
    assign w_ext_b = {{DW{1'b0}}, i_operands.divisor};
    assign w_a     = w_ext_a[DW-1:0];
    assign w_b     = w_ext_b[DW-1:0];
    assign w_neg_a = w_a[DW-1];
    assign w_neg_b = w_b[DW-1];
    assign w_mag_a = w_neg_a ? (~w_a + {{(DW-1){1'b0}}, 1'b1}) : w_a;
    assign w_mag_b = w_neg_b ? (~w_b + {{(DW-1){1'b0}}, 1'b1}) : w_b;

    // restoring step: remainder shifts in the next dividend bit from r_quo
    assign w_shift = {r_rem[DW-2:0], r_quo[DW-1]};
    assign w_diff  = {1'b0, w_shift} - {1'b0, r_den};
    assign w_fits  = ~w_diff[DW];

    assign w_maxpos = {1'b0, {(DW-1){1'b1}}};

    always_comb begin
        priority if (r_den == '0) begin
            w_q      = w_maxpos;
            w_status = sid_pkg::ST_DIV0;
        end else if (r_neg) begin
            w_q      = ~r_quo + {{(DW-1){1'b0}}, 1'b1};
            w_status = sid_pkg::ST_OK;
        end else if (r_quo[DW-1]) begin
            w_q      = w_maxpos;
            w_status = sid_pkg::ST_OVF;
        end else begin
            w_q      = r_quo;
            w_status = sid_pkg::ST_OK;
        end
    end

    assign w_q_ext = {{OW{1'b0}}, w_q};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= w_mag_b;
            r_quo <= w_mag_a;
            r_rem <= '0;
            r_neg <= w_neg_a ^ w_neg_b;
        end else if (i_cmd.step) begin
            r_rem <= w_fits ? w_diff[DW-1:0] : w_shift;
            r_quo <= {r_quo[DW-2:0], w_fits};
        end
        if (i_cmd.finish) begin
            r_result.quotient <= w_q_ext[OW-1:0];
            r_result.status   <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/signed_integer_divider.sv =====
// Channel   | Ports                        | Transfer
// ----------+------------------------------+----------------------------------------
// operands  | start, busy, i_operands      | edge with start high and busy low
// result    | o_done, o_result             | edge ending the single cycle o_done high
//
// Each division runs one restoring iteration per quotient bit on the shared subtractor,
// then sign fix and saturation into the result register.
// busy is high from the cycle after accept until the result register loads; a new item
// may be started in the o_done cycle itself.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops o_done.
// The receiver has no way to stall: a result is shown for one cycle only.

`include "signed_integer_divider_assert.svh"

module signed_integer_divider #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sid_pkg::t_div_in  i_operands,
    output logic              busy,
    output logic              o_done,
    output sid_pkg::t_div_out o_result
);

    // Controller sequences load -> DATA_WIDTH steps -> finish.
    sid_pkg::t_dp_cmd w_cmd;

    sid_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Datapath holds magnitudes, partial remainder and the quotient shift register.
    // Only the low DATA_WIDTH bits of each operand count; the sign is their top bit.
    // Quotient is negated when the signs differ; a positive quotient with its top bit
    // set (most negative over minus one) saturates and reports overflow; a zero divisor
    // yields the largest positive value with its own status.
    sid_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_operands (i_operands),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // A transfer in always brings the controller out of idle.
    `SID_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // Each transfer in is followed by the result strobe once the steps and the finish state are through.
    `SID_ASSERT_NOW(a_latency, start && !busy, ##(DATA_WIDTH + 2) o_done)
    // The result strobe only shows while the controller is idle.
    `SID_ASSERT_NOW(a_done_idle, o_done, !busy)
    // Only the finish command loads a result that is shown next.
    `SID_ASSERT_NEXT(a_finish_done, w_cmd.finish, o_done)

endmodule

// ===== test/tb_signed_integer_divider.sv =====
module tb_signed_integer_divider;
    timeunit 1ns;
    timeprecision 1ps;

    // Width the block is built with; the instance keeps its default.
    localparam int DW = sid_pkg::DATA_WIDTH_DEF;
    localparam int OW = sid_pkg::OPERAND_W;

    localparam logic signed [OW-1:0] MOST_NEG = {1'b1, {(OW-1){1'b0}}};
    localparam logic signed [OW-1:0] MOST_POS = {1'b0, {(OW-1){1'b1}}};

    // Cycles with no transfer on either side before the run is called hung.
    // The limit leaves ample room for a correct division plus the largest sender gap.
    localparam int IDLE_LIMIT = 10 * (DW + 8);

    localparam int RANDOM_ITEMS = 700;

    // Expected quotients, oldest first. Each quotient depends only on its own
    // operands, so each accepted operand pair maps straight to one expected result.
    class t_quotient_board;
        sid_pkg::t_div_out pending_q[$];
        int unsigned       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Truncating signed division on DW-bit operands, with saturation of the
        // one overflowing case and a distinct code for a zero divisor.
        function sid_pkg::t_div_out quotient_for(sid_pkg::t_div_in op);
            logic [DW-1:0]     num_raw, den_raw, num_mag, den_mag, quo;
            logic              num_neg, den_neg;
            sid_pkg::t_div_out res;
            num_raw = op.dividend[DW-1:0];
            den_raw = op.divisor[DW-1:0];
            num_neg = num_raw[DW-1];
            den_neg = den_raw[DW-1];
            num_mag = num_neg ? -num_raw : num_raw;
            den_mag = den_neg ? -den_raw : den_raw;
            res = '0;
            if (den_mag == '0) begin
                res.quotient = {1'b0, {(DW-1){1'b1}}};
                res.status   = sid_pkg::ST_DIV0;
                return res;
            end
            quo = num_mag / den_mag;
            res.status = sid_pkg::ST_OK;
            if (num_neg != den_neg) begin
                quo = -quo;
            end else if (quo[DW-1]) begin
                // only the most negative value over minus one gets here
                quo        = {1'b0, {(DW-1){1'b1}}};
                res.status = sid_pkg::ST_OVF;
            end
            res.quotient = quo;
            return res;
        endfunction

        function void note_operands(sid_pkg::t_div_in op);
            pending_q.push_back(quotient_for(op));
        endfunction

        function void check_result(sid_pkg::t_div_out got);
            sid_pkg::t_div_out want;
            if (pending_q.size() == 0) begin
                $error("result with nothing pending: quotient %0d status %0d",
                       got.quotient, got.status);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got.quotient !== want.quotient) begin
                $error("quotient: expected %0d, actual %0d", want.quotient, got.quotient);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    sid_pkg::t_div_in  i_operands = '0;
    logic              busy;
    logic              o_done;
    sid_pkg::t_div_out o_result;

    t_quotient_board   board = new();
    int                idle_cycles = 0;

    signed_integer_divider u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_operands (i_operands),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Result side: o_done is a one-cycle strobe and cannot be held off, so
    // every edge that sees it high is a transfer. Sampling at the edge reads
    // the values that stood during the cycle that edge ends.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_result(o_result);
        end
    end

    // Watchdog: counts edges with neither an operand nor a result transfer.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n && start && !busy) || (i_rst_n && o_done)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_signed_integer_divider: errors");
        $finish;
    end

    // Called at a rising edge. Holds start low for gap cycles, then presents
    // the pair and waits for the edge that takes it (start high, busy low).
    // start stays high on return so back-to-back transfers need no dip.
    task automatic send_operands(input sid_pkg::t_div_in op, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_operands <= op;
        do @(posedge i_clk); while (busy);
        board.note_operands(op);
    endtask

    task automatic send_pair(input logic signed [OW-1:0] num,
                             input logic signed [OW-1:0] den);
        sid_pkg::t_div_in op;
        op.dividend = num;
        op.divisor  = den;
        send_operands(op, $urandom_range(0, 4));
    endtask

    // Sender backs off until every pending quotient has come out.
    task automatic drain_quotients();
        start <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range words, small values around zero, the edge values and
    // magnitudes of every size so quotients of all lengths show up.
    function automatic logic signed [OW-1:0] random_operand();
        logic [OW-1:0] raw;
        case ($urandom_range(0, 5))
            0, 1: raw = $urandom;
            2: raw = $urandom_range(0, 40) - 20;
            3: begin
                case ($urandom_range(0, 4))
                    0: raw = '0;
                    1: raw = 1;
                    2: raw = '1;
                    3: raw = MOST_NEG;
                    default: raw = MOST_POS;
                endcase
            end
            default: begin
                raw = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    raw = -raw;
                end
            end
        endcase
        return raw;
    endfunction

    initial begin
        sid_pkg::t_div_in op;
        logic             no_gaps;
        int unsigned      gap;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: sign combinations, zero dividend, divide by zero with
        // various dividends, the saturating most-negative over minus one,
        // and the extremes of both operands.
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(0, 0);
        send_pair(7, 2);
        send_pair(-7, 2);
        send_pair(7, -2);
        send_pair(-7, -2);
        send_pair(MOST_NEG, -1);
        send_pair(MOST_NEG, 1);
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(MOST_NEG, 2);
        send_pair(MOST_NEG, 0);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MOST_POS, MOST_POS);
        send_pair(MOST_POS, -1);
        send_pair(MOST_POS, 1);
        send_pair(MOST_POS, 0);
        send_pair(5, 0);
        send_pair(-5, 0);
        send_pair(1, MOST_POS);
        send_pair(-1, MOST_NEG);
        send_pair(3, 7);
        send_pair(-1, -1);
        drain_quotients();

        // Random part. Gaps are redrawn per item; every 64 items a run may
        // switch to back-to-back transfers to hit the start-during-done path.
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                drain_quotients();
            end
            op.dividend = random_operand();
            op.divisor  = random_operand();
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            send_operands(op, gap);
        end

        drain_quotients();
        // let any stray strobe show up before the verdict
        repeat (DW + 4) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("tb_signed_integer_divider: clean");
        end else begin
            $display("tb_signed_integer_divider: errors");
        end
        $finish;
    end

endmodule
